// ===== rtl/core/doubly_linked_list_engine_defines.svh =====
// ---------------------------------------------------------------------------
// doubly linked list engine assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH
`define DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define DLL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dll check failed");

// next-cycle implication outside reset
`define DLL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dll check failed");

`endif

// ===== rtl/core/dll_pkg.sv =====
// ---------------------------------------------------------------------------
// dll_pkg
// shared constants and codes for the doubly linked list engine
// ---------------------------------------------------------------------------
package dll_pkg;

    localparam int Capacity   = 256;
    localparam int ValueWidth = 32;
    localparam int SlotWidth  = $clog2(Capacity);
    localparam int LinkWidth  = SlotWidth + 1;
    localparam int LenWidth   = 9;

    localparam logic [3:0] OP_APPEND    = 4'd0;
    localparam logic [3:0] OP_PREPEND   = 4'd1;
    localparam logic [3:0] OP_DEL_FIRST = 4'd2;
    localparam logic [3:0] OP_DEL_LAST  = 4'd3;
    localparam logic [3:0] OP_READ      = 4'd4;
    localparam logic [3:0] OP_WRITE     = 4'd5;
    localparam logic [3:0] OP_INSERT    = 4'd6;
    localparam logic [3:0] OP_DELETE    = 4'd7;
    localparam logic [3:0] OP_REVERSE   = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [LinkWidth-1:0] NIL = LinkWidth'(Capacity);

endpackage

// ===== rtl/core/dll_ram.sv =====
// ---------------------------------------------------------------------------
// dll_ram
// generic single-port-write, one-read synchronous ram with registered read
// ---------------------------------------------------------------------------
module dll_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/doubly_linked_list_engine.sv =====
// indexed requests walk from the nearer end, at most length / 2 hops
// reverse visits every node
// a new request is taken only when idle; busy stays high while done is shown
// after reset the free-slot stack fills, one entry a cycle, busy high
// reset is asynchronous active low and leaves the list empty; the receiver cannot stall
// ---------------------------------------------------------------------------
// doubly_linked_list_engine
// bounded doubly linked list held in node, link and free-slot memories
// ---------------------------------------------------------------------------
module doubly_linked_list_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [3:0]  req_type,
    input  logic [8:0]  position,
    input  logic signed [31:0] item_value,
    output logic [1:0]  status,
    output logic signed [31:0] read_value,
    output logic [8:0]  list_length,
    output logic signed [31:0] head_value,
    output logic signed [31:0] tail_value
);

    localparam int SW = dll_pkg::SlotWidth;
    localparam int LW = dll_pkg::LinkWidth;
    localparam int VW = dll_pkg::ValueWidth;
    localparam int NW = dll_pkg::LenWidth;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DECIDE, S_FREE_RD, S_FREE_WAIT, S_LINK_NEW,
        S_WALK_RD, S_WALK_WAIT, S_AT_NODE, S_INS_WAIT, S_DEL_RD, S_DEL_WAIT,
        S_DEL_LINK, S_REV_RD, S_REV_WAIT, S_REV_WR, S_HT_RD, S_HT_WAIT,
        S_HT_WAIT2, S_DONE
    } state_t;

    state_t state_reg;

    logic [3:0]    op_reg;
    logic [NW-1:0] pos_reg;
    logic [VW-1:0] val_reg;
    logic [1:0]    st_reg;
    logic [VW-1:0] rd_reg;
    logic [NW-1:0] cnt_reg;
    logic [LW-1:0] head_reg, tail_reg;
    logic [NW-1:0] free_reg;
    logic [LW-1:0] cur_reg;
    logic [NW-1:0] k_reg;
    logic          fwd_reg;
    logic [SW-1:0] new_reg;
    logic [SW-1:0] init_reg;
    logic [1:0]    sub_reg;
    logic [VW-1:0] hv_reg, tv_reg;
    logic          done_reg;

    logic          v_we, n_we, p_we, f_we;
    logic [SW-1:0] v_wa, n_wa, p_wa, f_wa;
    logic [SW-1:0] v_ra, n_ra, p_ra, f_ra;
    logic [VW-1:0] v_wd, v_rd;
    logic [LW-1:0] n_wd, n_rd, p_wd, p_rd;
    logic [SW-1:0] f_wd, f_rd;

    dll_ram #(.Width(VW), .Depth(dll_pkg::Capacity)) u_val (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
    dll_ram #(.Width(LW), .Depth(dll_pkg::Capacity)) u_next (
        .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
    dll_ram #(.Width(LW), .Depth(dll_pkg::Capacity)) u_prev (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
    dll_ram #(.Width(SW), .Depth(dll_pkg::Capacity)) u_free (
        .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

    logic [SW-1:0] cur_s;
    assign cur_s = cur_reg[SW-1:0];

    // node fields come from the walk position, or hold neighbours during relink
    logic [LW-1:0] np_reg, nn_reg;

    always_comb
    begin
        v_we = 1'b0; n_we = 1'b0; p_we = 1'b0; f_we = 1'b0;
        v_wa = cur_s; n_wa = cur_s; p_wa = cur_s; f_wa = free_reg[SW-1:0];
        v_wd = val_reg; n_wd = dll_pkg::NIL; p_wd = dll_pkg::NIL; f_wd = cur_s;
        v_ra = cur_s; n_ra = cur_s; p_ra = cur_s;
        f_ra = SW'(free_reg - NW'(1));
        case (state_reg)
            S_INIT:
            begin
                f_we = 1'b1;
                f_wa = init_reg;
                f_wd = SW'(dll_pkg::Capacity - 1) - init_reg;
            end
            S_LINK_NEW:
            begin
                // new node: value, and its own links
                v_we = 1'b1; v_wa = new_reg;
                n_we = 1'b1; n_wa = new_reg; n_wd = nn_reg;
                p_we = 1'b1; p_wa = new_reg; p_wd = np_reg;
            end
            S_INS_WAIT:
            begin
                // neighbours point at the new node
                if (sub_reg == 2'd0)
                begin
                    if (np_reg != dll_pkg::NIL)
                    begin
                        n_we = 1'b1; n_wa = np_reg[SW-1:0]; n_wd = {1'b0, new_reg};
                    end
                    if (nn_reg != dll_pkg::NIL)
                    begin
                        p_we = 1'b1; p_wa = nn_reg[SW-1:0]; p_wd = {1'b0, new_reg};
                    end
                end
            end
            S_AT_NODE:
            begin
                if (op_reg == dll_pkg::OP_WRITE)
                begin
                    v_we = 1'b1;
                end
            end
            S_DEL_LINK:
            begin
                if (np_reg != dll_pkg::NIL)
                begin
                    n_we = 1'b1; n_wa = np_reg[SW-1:0]; n_wd = nn_reg;
                end
                if (nn_reg != dll_pkg::NIL)
                begin
                    p_we = 1'b1; p_wa = nn_reg[SW-1:0]; p_wd = np_reg;
                end
                f_we = 1'b1; f_wa = free_reg[SW-1:0]; f_wd = cur_s;
            end
            S_REV_WR:
            begin
                n_we = 1'b1; n_wd = p_rd;
                p_we = 1'b1; p_wd = n_rd;
            end
            S_HT_RD:
            begin
                v_ra = head_reg[SW-1:0];
            end
            S_HT_WAIT:
            begin
                v_ra = tail_reg[SW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    logic full_w;
    assign full_w = (cnt_reg >= NW'(dll_pkg::Capacity));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg  <= '0;
            cnt_reg   <= '0;
            head_reg  <= dll_pkg::NIL;
            tail_reg  <= dll_pkg::NIL;
            free_reg  <= NW'(dll_pkg::Capacity);
            done_reg  <= 1'b0;
            sub_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + SW'(1);
                    if (init_reg == SW'(dll_pkg::Capacity - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= req_type;
                        pos_reg   <= position;
                        val_reg   <= item_value;
                        st_reg    <= dll_pkg::ST_OK;
                        rd_reg    <= '0;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= S_HT_RD;
                    case (op_reg)
                        dll_pkg::OP_APPEND, dll_pkg::OP_PREPEND:
                        begin
                            if (full_w) st_reg <= dll_pkg::ST_FULL;
                            else
                            begin
                                np_reg <= (op_reg == dll_pkg::OP_APPEND) ? tail_reg : dll_pkg::NIL;
                                nn_reg <= (op_reg == dll_pkg::OP_APPEND) ? dll_pkg::NIL : head_reg;
                                state_reg <= S_FREE_RD;
                            end
                        end
                        dll_pkg::OP_DEL_FIRST, dll_pkg::OP_DEL_LAST:
                        begin
                            if (cnt_reg == '0) st_reg <= dll_pkg::ST_EMPTY;
                            else state_reg <= S_DEL_RD;
                        end
                        dll_pkg::OP_READ, dll_pkg::OP_WRITE:
                        begin
                            if (pos_reg >= cnt_reg) st_reg <= dll_pkg::ST_RANGE;
                            else state_reg <= S_WALK_RD;
                        end
                        dll_pkg::OP_INSERT:
                        begin
                            if (full_w) st_reg <= dll_pkg::ST_FULL;
                            else if (pos_reg > cnt_reg) st_reg <= dll_pkg::ST_RANGE;
                            else if (pos_reg == cnt_reg || pos_reg == '0)
                            begin
                                np_reg <= (pos_reg == cnt_reg) ? tail_reg : dll_pkg::NIL;
                                nn_reg <= (pos_reg == cnt_reg) ? dll_pkg::NIL : head_reg;
                                op_reg <= (pos_reg == cnt_reg) ? dll_pkg::OP_APPEND
                                                               : dll_pkg::OP_PREPEND;
                                state_reg <= S_FREE_RD;
                            end
                            else state_reg <= S_WALK_RD;
                        end
                        dll_pkg::OP_DELETE:
                        begin
                            if (cnt_reg == '0) st_reg <= dll_pkg::ST_EMPTY;
                            else if (pos_reg >= cnt_reg) st_reg <= dll_pkg::ST_RANGE;
                            else state_reg <= S_WALK_RD;
                        end
                        dll_pkg::OP_REVERSE:
                        begin
                            if (cnt_reg >= NW'(2))
                            begin
                                state_reg <= S_REV_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    fwd_reg <= (pos_reg < (cnt_reg >> 1));
                    if (op_reg == dll_pkg::OP_DEL_FIRST)
                    begin
                        cur_reg <= head_reg;
                        k_reg   <= '0;
                    end
                    else if (op_reg == dll_pkg::OP_DEL_LAST)
                    begin
                        cur_reg <= tail_reg;
                        k_reg   <= '0;
                    end
                    else if (op_reg == dll_pkg::OP_REVERSE)
                    begin
                        cur_reg <= head_reg;
                        k_reg   <= '0;
                    end
                    else
                    begin
                        cur_reg <= (pos_reg < (cnt_reg >> 1)) ? head_reg : tail_reg;
                        k_reg   <= (pos_reg < (cnt_reg >> 1)) ? '0 : cnt_reg - NW'(1);
                    end
                end
                S_WALK_RD:
                begin
                    if (k_reg == pos_reg) state_reg <= S_AT_NODE;
                    else state_reg <= S_WALK_WAIT;
                end
                S_WALK_WAIT:
                begin
                    cur_reg   <= fwd_reg ? n_rd : p_rd;
                    k_reg     <= fwd_reg ? k_reg + NW'(1) : k_reg - NW'(1);
                    state_reg <= S_WALK_RD;
                end
                S_AT_NODE:
                begin
                    // read data for cur is valid here
                    case (op_reg)
                        dll_pkg::OP_READ:
                        begin
                            rd_reg    <= v_rd;
                            state_reg <= S_HT_RD;
                        end
                        dll_pkg::OP_WRITE:  state_reg <= S_HT_RD;
                        dll_pkg::OP_INSERT:
                        begin
                            np_reg    <= p_rd;
                            nn_reg    <= cur_reg;
                            state_reg <= S_FREE_RD;
                        end
                        default:
                        begin
                            np_reg    <= p_rd;
                            nn_reg    <= n_rd;
                            state_reg <= S_DEL_LINK;
                        end
                    endcase
                end
                S_FREE_RD:
                begin
                    state_reg <= S_FREE_WAIT;
                end
                S_FREE_WAIT:
                begin
                    new_reg   <= f_rd;
                    free_reg  <= free_reg - NW'(1);
                    state_reg <= S_LINK_NEW;
                end
                S_LINK_NEW:
                begin
                    cnt_reg <= cnt_reg + NW'(1);
                    if (np_reg == dll_pkg::NIL) head_reg <= {1'b0, new_reg};
                    if (nn_reg == dll_pkg::NIL) tail_reg <= {1'b0, new_reg};
                    sub_reg   <= 2'd0;
                    state_reg <= S_INS_WAIT;
                end
                S_INS_WAIT:
                begin
                    state_reg <= S_HT_RD;
                end
                S_DEL_RD:
                begin
                    state_reg <= S_DEL_WAIT;
                end
                S_DEL_WAIT:
                begin
                    np_reg    <= p_rd;
                    nn_reg    <= n_rd;
                    state_reg <= S_DEL_LINK;
                end
                S_DEL_LINK:
                begin
                    if (np_reg == dll_pkg::NIL) head_reg <= nn_reg;
                    if (nn_reg == dll_pkg::NIL) tail_reg <= np_reg;
                    free_reg  <= free_reg + NW'(1);
                    cnt_reg   <= cnt_reg - NW'(1);
                    state_reg <= S_HT_RD;
                end
                S_REV_RD:
                begin
                    state_reg <= S_REV_WAIT;
                end
                S_REV_WAIT:
                begin
                    state_reg <= S_REV_WR;
                end
                S_REV_WR:
                begin
                    k_reg <= k_reg + NW'(1);
                    if (n_rd == dll_pkg::NIL || k_reg + NW'(1) >= cnt_reg)
                    begin
                        head_reg  <= tail_reg;
                        tail_reg  <= head_reg;
                        state_reg <= S_HT_RD;
                    end
                    else
                    begin
                        cur_reg   <= n_rd;
                        state_reg <= S_REV_RD;
                    end
                end
                S_HT_RD:
                begin
                    state_reg <= S_HT_WAIT;
                end
                S_HT_WAIT:
                begin
                    hv_reg    <= (head_reg == dll_pkg::NIL) ? '0 : v_rd;
                    state_reg <= S_HT_WAIT2;
                end
                S_HT_WAIT2:
                begin
                    tv_reg    <= (tail_reg == dll_pkg::NIL) ? '0 : v_rd;
                    done_reg  <= 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = st_reg;
    assign read_value  = rd_reg;
    assign list_length = cnt_reg;
    assign head_value  = hv_reg;
    assign tail_value  = tv_reg;

endmodule

// ===== rtl/core/dll_checker.sv =====
// ---------------------------------------------------------------------------
// dll_checker
// port-level checks on the doubly linked list engine
// ---------------------------------------------------------------------------
`include "doubly_linked_list_engine_defines.svh"

module dll_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic signed [31:0] read_value,
    input logic [8:0]  list_length,
    input logic signed [31:0] head_value,
    input logic signed [31:0] tail_value
);

    `DLL_ASSERT_IMP(a_len_cap, done, list_length <= 9'd256)
    `DLL_ASSERT_IMP(a_empty_zero, done && list_length == 9'd0,
        head_value == 32'sd0 && tail_value == 32'sd0)
    `DLL_ASSERT_IMP(a_rd_ok, done && status != dll_pkg::ST_OK, read_value == 32'sd0)
    `DLL_ASSERT_NEXT(a_req_busy, start && !busy, busy)
    `DLL_ASSERT_NEXT(a_done_once, done, !done)

endmodule

bind doubly_linked_list_engine dll_checker u_dll_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .read_value(read_value), .list_length(list_length),
    .head_value(head_value), .tail_value(tail_value));
